/* hdl/bocnt_pkg.sv */
// Shared types, constants and the coil phase table for the occupancy counter.
// No dependencies; every other file in hdl/ imports this package.
package bocnt_pkg;

   localparam int CapWidth          = 6;
   localparam int OccWidth          = 6;
   localparam int OutTotalWidth     = 16;
   localparam int LedWidth          = 16;
   localparam int CoilWidth         = 6;
   localparam int PhaseWidth        = 2;
   localparam int TotalWidthDefault = 16;
   localparam int LedCountDefault   = 16;

   localparam logic [CapWidth-1:0] CapReset = 6'd20;

   typedef struct packed {
      logic entry_beam;
      logic exit_beam;
   } req_type;

   typedef struct packed {
      logic [OccWidth-1:0]      occupancy;
      logic [OutTotalWidth-1:0] entered_total;
      logic [OutTotalWidth-1:0] left_total;
      logic [LedWidth-1:0]      led_bar;
      logic [CoilWidth-1:0]     coil_pattern;
      logic                     coil_update;
      logic                     coil_reverse;
   } rsp_type;

   function automatic logic [CoilWidth-1:0] coil_word(input logic [PhaseWidth-1:0] phase);
      logic [CoilWidth-1:0] word;
      case (phase)
         2'd0:    word = 6'h1F;
         2'd1:    word = 6'h3F;
         2'd2:    word = 6'h2F;
         2'd3:    word = 6'h17;
         default: word = 6'h1F;
      endcase
      return word;
   endfunction

endpackage

/* hdl/bocnt_csr.sv */
// Capacity register behind the csr write channel.
// Depends on bocnt_pkg for the register width and reset value.
module bocnt_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bocnt_pkg::CapWidth-1:0] csr_data,
   output logic [bocnt_pkg::CapWidth-1:0] cap_limit
);
   import bocnt_pkg::*;

   logic [CapWidth-1:0] capacity_ff;
   logic [CapWidth-1:0] capacity_in;

   assign csr_ready = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_valid) begin
         capacity_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapReset;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign cap_limit = capacity_ff;

endmodule

/* hdl/bocnt_core.sv */
// Occupancy, totals, locks, coil phase and LED state with the per-item update logic.
// Depends on bocnt_pkg for item types and the coil table.
module bocnt_core #(
   parameter int TOTAL_WIDTH = bocnt_pkg::TotalWidthDefault,
   parameter int LED_COUNT   = bocnt_pkg::LedCountDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  bocnt_pkg::req_type            item,
   input  logic [bocnt_pkg::CapWidth-1:0] cap_limit,
   output bocnt_pkg::rsp_type            result
);
   import bocnt_pkg::*;

   localparam logic [5:0] LedLimit = 6'(LED_COUNT);

   logic [OccWidth-1:0]    occ_ff, occ_in, occ_mid;
   logic [TOTAL_WIDTH-1:0] entered_ff, entered_in;
   logic [TOTAL_WIDTH-1:0] left_ff, left_in;
   logic                   entry_lock_ff, entry_lock_in, lock_mid;
   logic                   exit_lock_ff, exit_lock_in;
   logic [PhaseWidth-1:0]  phase_ff, phase_in;
   logic [LedWidth-1:0]    led_ff, led_in, therm;
   logic                   entry_hit, exit_hit;
   logic [5:0]             lit;
   logic [TOTAL_WIDTH+OutTotalWidth-1:0] entered_ext, left_ext;

   always_comb begin
      entry_hit = !item.entry_beam && !exit_lock_ff && (occ_ff < cap_limit);
      occ_mid   = entry_hit ? occ_ff + 6'd1 : occ_ff;
      lock_mid  = entry_lock_ff | entry_hit;
      exit_hit  = !item.exit_beam && !lock_mid && (occ_mid != '0);
      occ_in    = exit_hit ? occ_mid - 6'd1 : occ_mid;

      entered_in = entered_ff;
      if (entry_hit && (entered_ff != '1)) begin
         entered_in = entered_ff + TOTAL_WIDTH'(1);
      end
      left_in = left_ff;
      if (exit_hit && (left_ff != '1)) begin
         left_in = left_ff + TOTAL_WIDTH'(1);
      end

      phase_in = phase_ff;
      if (entry_hit) begin
         phase_in = phase_ff + 2'd1;
      end else if (exit_hit) begin
         phase_in = phase_ff - 2'd1;
      end

      if (item.entry_beam && item.exit_beam) begin
         entry_lock_in = 1'b0;
         exit_lock_in  = 1'b0;
      end else begin
         entry_lock_in = lock_mid;
         exit_lock_in  = exit_lock_ff | exit_hit;
      end

      lit = {1'b0, occ_in[OccWidth-1:1]};
      if (lit > LedLimit) begin
         lit = LedLimit;
      end
      for (int i = 0; i < LedWidth; i++) begin
         therm[i] = (6'(i) < lit);
      end
      led_in = (entry_hit || exit_hit) ? therm : led_ff;
   end

   assign entered_ext = {{OutTotalWidth{1'b0}}, entered_in};
   assign left_ext    = {{OutTotalWidth{1'b0}}, left_in};

   always_comb begin
      result.occupancy     = occ_in;
      result.entered_total = entered_ext[OutTotalWidth-1:0];
      result.left_total    = left_ext[OutTotalWidth-1:0];
      result.led_bar       = led_in;
      result.coil_pattern  = coil_word(phase_ff);
      result.coil_update   = entry_hit | exit_hit;
      result.coil_reverse  = exit_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff        <= '0;
         entered_ff    <= '0;
         left_ff       <= '0;
         entry_lock_ff <= 1'b0;
         exit_lock_ff  <= 1'b0;
         phase_ff      <= '0;
         led_ff        <= '0;
      end else if (advance) begin
         occ_ff        <= occ_in;
         entered_ff    <= entered_in;
         left_ff       <= left_in;
         entry_lock_ff <= entry_lock_in;
         exit_lock_ff  <= exit_lock_in;
         phase_ff      <= phase_in;
         led_ff        <= led_in;
      end
   end

endmodule

/* hdl/bidirectional_occupancy_counter_top.sv */
// Each accepted item waits in the input register; its result goes to the result register.
// One item per cycle unless stalled; the update is a single pass over the held state.
// Stalls only when both registers are full and the waiting result is not taken.
// Reset (synchronous, active high) clears counts, locks, coil phase and LED word
// and loads capacity 20. Depends on bocnt_pkg, bocnt_csr and bocnt_core.
module bidirectional_occupancy_counter_top #(
   parameter int TOTAL_WIDTH = bocnt_pkg::TotalWidthDefault,
   parameter int LED_COUNT   = bocnt_pkg::LedCountDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bocnt_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bocnt_pkg::rsp_type            rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bocnt_pkg::CapWidth-1:0] csr_data
);
   import bocnt_pkg::*;

   logic                in_valid_ff, in_valid_in;
   req_type             in_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             result;
   logic [CapWidth-1:0] cap_limit;
   logic                out_free, advance, req_take;

   bocnt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cap_limit (cap_limit)
   );

   bocnt_core #(
      .TOTAL_WIDTH (TOTAL_WIDTH),
      .LED_COUNT   (LED_COUNT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (in_data_ff),
      .cap_limit (cap_limit),
      .result    (result)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      advance      = in_valid_ff && out_free;
      req_ready    = !in_valid_ff || out_free;
      req_take     = req_valid && req_ready;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_reverse_needs_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.coil_reverse || rsp_data_ff.coil_update))
      else $error("reverse flagged without a step");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled while a register is free");

   a_input_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(in_valid_ff) |-> $past(req_valid && req_ready))
      else $error("input register filled without an accepted item");
`endif

endmodule

/* tb/occupancy_tally_checker.sv */
// Checker for the occupancy counter: watches the poll, result and capacity channels,
// predicts each result from its own copy of the counter state and compares field by field.
// Depends on bocnt_pkg for the channel types and widths.
module occupancy_tally_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  bocnt_pkg::req_type             req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  bocnt_pkg::rsp_type             rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bocnt_pkg::CapWidth-1:0] csr_data,
   output int                             mismatches,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import bocnt_pkg::*;

   localparam int TallyWidth = TotalWidthDefault;
   localparam logic [3:0][CoilWidth-1:0] CoilWords = {6'h17, 6'h2F, 6'h3F, 6'h1F};

   logic [CapWidth-1:0]   room_limit;
   logic [OccWidth-1:0]   people_in;
   logic [TallyWidth-1:0] entries_seen;
   logic [TallyWidth-1:0] exits_seen;
   logic                  entry_latched;
   logic                  exit_latched;
   logic [PhaseWidth-1:0] step_phase;
   logic [LedWidth-1:0]   led_shadow;
   rsp_type               expected_tallies[$];

   function automatic logic [LedWidth-1:0] led_level(input logic [OccWidth-1:0] heads);
      int lit;
      logic [63:0] ones;
      lit = heads / 2;
      if (lit > LedCountDefault)
         lit = LedCountDefault;
      ones = (64'd1 << lit) - 64'd1;
      return ones[LedWidth-1:0];
   endfunction

   function automatic rsp_type tally_poll(input req_type poll);
      rsp_type res;
      logic [PhaseWidth-1:0] start_phase;
      start_phase = step_phase;
      res = '0;
      if (!poll.entry_beam && !exit_latched && people_in < room_limit) begin
         if (entries_seen != '1)
            entries_seen = entries_seen + 1'b1;
         people_in = people_in + 1'b1;
         entry_latched = 1'b1;
         led_shadow = led_level(people_in);
         step_phase = start_phase + 1'b1;
         res.coil_update = 1'b1;
      end
      if (!poll.exit_beam && !entry_latched && people_in != '0) begin
         if (exits_seen != '1)
            exits_seen = exits_seen + 1'b1;
         people_in = people_in - 1'b1;
         exit_latched = 1'b1;
         led_shadow = led_level(people_in);
         step_phase = start_phase - 1'b1;
         res.coil_update = 1'b1;
         res.coil_reverse = 1'b1;
      end
      if (poll.entry_beam && poll.exit_beam) begin
         entry_latched = 1'b0;
         exit_latched = 1'b0;
      end
      res.occupancy = people_in;
      res.entered_total = entries_seen[OutTotalWidth-1:0];
      res.left_total = exits_seen[OutTotalWidth-1:0];
      res.led_bar = led_shadow;
      res.coil_pattern = CoilWords[start_phase];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("%0t tally mismatch: %s got %0h want %0h", $time, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         room_limit = CapReset;
         people_in = '0;
         entries_seen = '0;
         exits_seen = '0;
         entry_latched = 1'b0;
         exit_latched = 1'b0;
         step_phase = '0;
         led_shadow = '0;
         expected_tallies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tallies.size() == 0) begin
               report_mismatch("result with no poll waiting", rsp_data, '0);
            end else begin
               want = expected_tallies.pop_front();
               check_field("occupancy", rsp_data.occupancy, want.occupancy);
               check_field("entered_total", rsp_data.entered_total, want.entered_total);
               check_field("left_total", rsp_data.left_total, want.left_total);
               check_field("led_bar", rsp_data.led_bar, want.led_bar);
               check_field("coil_pattern", rsp_data.coil_pattern, want.coil_pattern);
               check_field("coil_update", rsp_data.coil_update, want.coil_update);
               check_field("coil_reverse", rsp_data.coil_reverse, want.coil_reverse);
            end
         end
         if (req_valid && req_ready)
            expected_tallies.push_back(tally_poll(req_data));
         if (csr_valid && csr_ready)
            room_limit = csr_data;
      end
      pending = expected_tallies.size();
   end

endmodule

/* tb/bidirectional_occupancy_counter_top_tb.sv */
// Testbench top for the occupancy counter: drives sensor polls and capacity writes
// under several idle and stall mixes and gives the verdict from the checker's count.
// Depends on bocnt_pkg, occupancy_tally_checker and the counter RTL.
module bidirectional_occupancy_counter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bocnt_pkg::*;

   localparam int QuietLimit       = 2000;
   localparam int HoldoffCycles    = 300;
   localparam int SaturationRounds = 2;
   localparam int PhaseItems       = 150;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CapWidth-1:0] csr_data = '0;

   int mismatches;
   int pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int holdoff_request = 0;
   int quiet_cycles = 0;
   int polls_sent = 0;

   bidirectional_occupancy_counter_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   occupancy_tally_checker tally_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles == QuietLimit) begin
         $display("[bidirectional_occupancy_counter_top] ERROR");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (holdoff_request != 0) begin
            hold_left = holdoff_request;
            holdoff_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_poll(input logic entry_b, input logic exit_b);
      req_type poll;
      poll.entry_beam = entry_b;
      poll.exit_beam = exit_b;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= poll;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      polls_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CapWidth-1:0] cap);
      csr_valid <= 1'b1;
      csr_data <= cap;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly clean walks through one beam, then broken sequences and noise
   task automatic send_traffic(input int count);
      int first;
      int kind;
      int len;
      first = polls_sent;
      while (polls_sent - first < count) begin
         kind = $urandom_range(99);
         len = $urandom_range(1, 4);
         if (kind < 45) begin
            repeat (len) send_poll(1'b0, 1'b1);
            repeat ($urandom_range(1, 2)) send_poll(1'b1, 1'b1);
         end else if (kind < 80) begin
            repeat (len) send_poll(1'b1, 1'b0);
            repeat ($urandom_range(1, 2)) send_poll(1'b1, 1'b1);
         end else if (kind < 90) begin
            send_poll(1'b0, 1'b1);
            send_poll(1'b0, 1'b0);
            send_poll(1'b1, 1'b0);
         end else
            send_poll(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_poll(1'b1, 1'b1);
      send_poll(1'b1, 1'b0);
      send_poll(1'b0, 1'b1);
      send_poll(1'b0, 1'b1);
      send_poll(1'b0, 1'b0);
      send_poll(1'b1, 1'b1);
      send_poll(1'b1, 1'b0);
      send_poll(1'b1, 1'b0);
      send_poll(1'b0, 1'b1);
      send_poll(1'b0, 1'b0);
      send_poll(1'b1, 1'b0);
      send_poll(1'b1, 1'b1);
      drain();
      write_capacity(6'd0);
      send_poll(1'b0, 1'b1);
      send_poll(1'b1, 1'b1);
      drain();
      write_capacity(6'd1);
      send_poll(1'b0, 1'b1);
      send_poll(1'b0, 1'b1);
      send_poll(1'b1, 1'b1);
      send_poll(1'b1, 1'b0);
      send_poll(1'b1, 1'b1);

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            0: write_capacity(6'd32);
            1: write_capacity(6'd0);
            2: write_capacity(6'd63);
            3: write_capacity(6'd1);
            6: write_capacity(6'($urandom_range(63)));
            default: write_capacity(6'($urandom_range(2, 40)));
         endcase
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 62; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 62; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         if (phase == 4) begin
            send_traffic(40);
            holdoff_request = HoldoffCycles;
            send_traffic(PhaseItems - 40);
         end else if (phase == 5) begin
            send_traffic(90);
            drain();
            send_traffic(PhaseItems - 90);
         end else
            send_traffic(PhaseItems);
      end

      // fill the room to the top and empty it again
      drain();
      idle_pct = 0;
      stall_pct = 0;
      write_capacity(6'd63);
      repeat (SaturationRounds) begin
         repeat (63) send_poll(1'b0, 1'b1);
         send_poll(1'b1, 1'b1);
         repeat (63) send_poll(1'b1, 1'b0);
         send_poll(1'b1, 1'b1);
      end

      drain();
      idle_pct = 25;
      stall_pct = 25;
      write_capacity(6'd20);
      send_traffic(60);

      drain();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && pending == 0)
         $display("[bidirectional_occupancy_counter_top] OK");
      else
         $display("[bidirectional_occupancy_counter_top] ERROR");
      $finish;
   end

endmodule
